// ----- rtl/core/vtbb_pkg.sv -----
// shared constants and types for the vertex transform and bounding box unit
`timescale 1ns / 1ps
`default_nettype none

package vtbb_pkg;

  // default field widths
  localparam int COORD_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF  = 20;

  // configuration register index
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_ROW_X        = 3'd0,
    CFG_ROW_Y        = 3'd1,
    CFG_ROW_Z        = 3'd2,
    CFG_SHIFT_X      = 3'd3,
    CFG_SHIFT_Y      = 3'd4,
    CFG_SHIFT_Z      = 3'd5,
    CFG_TRANSFORM_ON = 3'd6
  } cfg_index_t;

  // load strobes for the two arithmetic stages of each axis
  typedef struct packed {
    logic load_prod;
    logic load_cam;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/vtbb_axis.sv -----
// one output axis: registered products, then sum, floor, saturate and bypass
`timescale 1ns / 1ps
`default_nettype none

module vtbb_axis #(
  parameter int COORD_WIDTH = vtbb_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = vtbb_pkg::COEF_WIDTH_DEF
) (
  input  logic                          clk,
  input  vtbb_pkg::stage_ctl_t          ctl,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic signed [COORD_WIDTH-1:0] vertex_z,
  input  logic signed [COORD_WIDTH-1:0] pass_in,
  input  logic [3*COEF_WIDTH-1:0]       coefs,
  input  logic signed [COORD_WIDTH-1:0] shift,
  input  logic                          transform_on,
  output logic signed [COORD_WIDTH-1:0] cam
);

  localparam int FRAC_BITS = COEF_WIDTH - 2;
  localparam int PROD_W    = COORD_WIDTH + COEF_WIDTH;
  localparam int SUM_W     = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [COEF_WIDTH-1:0]  coef_lane [3];
  logic signed [COORD_WIDTH-1:0] vin       [3];
  logic signed [PROD_W-1:0]      prod_next [3];
  logic signed [PROD_W-1:0]      prod      [3];
  logic signed [COORD_WIDTH-1:0] pass;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       floored;
  logic signed [COORD_WIDTH-1:0] cam_next;

  // coefficient lanes and their vertex operands
  always_comb begin
    vin[0] = vertex_x;
    vin[1] = vertex_y;
    vin[2] = vertex_z;
    for (int k = 0; k < 3; k++) begin
      coef_lane[k] = coefs[k*COEF_WIDTH +: COEF_WIDTH];
      prod_next[k] = PROD_W'(coef_lane[k]) * PROD_W'(vin[k]);
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= prod_next[k];
      end
      pass <= pass_in;
    end
  end

  // sum with translation, floor by the coefficient fraction, saturate, or bypass when off
  always_comb begin
    sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2])
        + (SUM_W'(shift) <<< FRAC_BITS);
    floored = sum >>> FRAC_BITS;
    if (!transform_on) begin
      cam_next = pass;
    end else if (floored > SAT_HI) begin
      cam_next = COORD_WIDTH'(SAT_HI);
    end else if (floored < SAT_LO) begin
      cam_next = COORD_WIDTH'(SAT_LO);
    end else begin
      cam_next = COORD_WIDTH'(floored);
    end
  end

  // transformed coordinate stage
  always_ff @(posedge clk) begin
    if (ctl.load_cam) begin
      cam <= cam_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/vertex_transform_bound_box_unit.sv -----
// top level: affine vertex transform with running axis-aligned bounding box
//
// Usage: vertices enter on the in_valid / in_ready channel (vertex_x/y/z in
// signed fixed point with 8 fraction bits, plus clear_box). Each transaction
// yields exactly one result transaction on out_valid / out_ready carrying the
// transformed point cam_x/y/z and the box after that point is folded in.
// clear_box empties the box first, so the box then holds just this point.
// Configuration is a write-only port (cfg_we, cfg_index, cfg_data); the user
// must write it only while no vertex is in flight, which the block itself does
// not enforce; unknown indexes are ignored. An accepted vertex passes the
// input, product, sum/saturate and output registers in that order.
// Throughput: one vertex per cycle unless the result side stalls, set by the
// box fold, a single min/max compare per axis in the output register stage.
// Reset: sync, active high; empties the pipeline, sets the identity matrix,
// zero translation, transform on, and an empty box.
// Stall: each stage holds while the stage after it is full and stalled;
// upstream stages with bubbles keep accepting vertices until all are full.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_bound_box_unit #(
  parameter int COORD_WIDTH = vtbb_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = vtbb_pkg::COEF_WIDTH_DEF,
  localparam int ROW_WIDTH  = 3 * COEF_WIDTH,
  localparam int CFG_WIDTH  = (ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration write port
  input  logic                                    cfg_we,
  input  logic [vtbb_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_WIDTH-1:0]                    cfg_data,
  // vertex channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [COORD_WIDTH-1:0]           vertex_x,
  input  logic signed [COORD_WIDTH-1:0]           vertex_y,
  input  logic signed [COORD_WIDTH-1:0]           vertex_z,
  input  logic                                    clear_box,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [COORD_WIDTH-1:0]           cam_x,
  output logic signed [COORD_WIDTH-1:0]           cam_y,
  output logic signed [COORD_WIDTH-1:0]           cam_z,
  output logic signed [COORD_WIDTH-1:0]           bound_min_x,
  output logic signed [COORD_WIDTH-1:0]           bound_max_x,
  output logic signed [COORD_WIDTH-1:0]           bound_min_y,
  output logic signed [COORD_WIDTH-1:0]           bound_max_y,
  output logic signed [COORD_WIDTH-1:0]           bound_min_z,
  output logic signed [COORD_WIDTH-1:0]           bound_max_z
);

  localparam int FRAC_BITS = COEF_WIDTH - 2;
  localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = ROW_WIDTH'(1) << FRAC_BITS;
  localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = ROW_WIDTH'(1) << (FRAC_BITS + COEF_WIDTH);
  localparam logic [ROW_WIDTH-1:0] ROW_Z_RESET = ROW_WIDTH'(1) << (FRAC_BITS + 2 * COEF_WIDTH);
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // configuration registers
  logic [ROW_WIDTH-1:0]          row_coefs [3];
  logic signed [COORD_WIDTH-1:0] shift     [3];
  logic                          transform_on;

  // pipeline control
  logic valid_a, valid_b, valid_c;
  logic ready_b, ready_c, ready_d;
  logic load_a, load_b, load_c, load_d;
  vtbb_pkg::stage_ctl_t axis_ctl;

  // stage payloads
  logic signed [COORD_WIDTH-1:0] vert_a [3];
  logic                          clear_a, clear_b, clear_c;
  logic signed [COORD_WIDTH-1:0] cam_c  [3];
  logic signed [COORD_WIDTH-1:0] cam_d  [3];
  logic signed [COORD_WIDTH-1:0] bmin      [3];
  logic signed [COORD_WIDTH-1:0] bmax      [3];
  logic signed [COORD_WIDTH-1:0] bmin_next [3];
  logic signed [COORD_WIDTH-1:0] bmax_next [3];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_coefs[0] <= ROW_X_RESET;
      row_coefs[1] <= ROW_Y_RESET;
      row_coefs[2] <= ROW_Z_RESET;
      shift[0]     <= '0;
      shift[1]     <= '0;
      shift[2]     <= '0;
      transform_on <= 1'b1;
    end else if (cfg_we) begin
      case (vtbb_pkg::cfg_index_t'(cfg_index))
        vtbb_pkg::CFG_ROW_X:        row_coefs[0] <= cfg_data[ROW_WIDTH-1:0];
        vtbb_pkg::CFG_ROW_Y:        row_coefs[1] <= cfg_data[ROW_WIDTH-1:0];
        vtbb_pkg::CFG_ROW_Z:        row_coefs[2] <= cfg_data[ROW_WIDTH-1:0];
        vtbb_pkg::CFG_SHIFT_X:      shift[0]     <= cfg_data[COORD_WIDTH-1:0];
        vtbb_pkg::CFG_SHIFT_Y:      shift[1]     <= cfg_data[COORD_WIDTH-1:0];
        vtbb_pkg::CFG_SHIFT_Z:      shift[2]     <= cfg_data[COORD_WIDTH-1:0];
        vtbb_pkg::CFG_TRANSFORM_ON: transform_on <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // per-stage ready: a stage takes a transaction when empty or draining
  always_comb begin
    ready_d  = !out_valid || out_ready;
    ready_c  = !valid_c || ready_d;
    ready_b  = !valid_b || ready_c;
    in_ready = !valid_a || ready_b;
    load_a   = in_valid && in_ready;
    load_b   = valid_a && ready_b;
    load_c   = valid_b && ready_c;
    load_d   = valid_c && ready_d;
    axis_ctl.load_prod = load_b;
    axis_ctl.load_cam  = load_c;
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_a) begin
        valid_a <= 1'b1;
      end else if (load_b) begin
        valid_a <= 1'b0;
      end
      if (load_b) begin
        valid_b <= 1'b1;
      end else if (load_c) begin
        valid_b <= 1'b0;
      end
      if (load_c) begin
        valid_c <= 1'b1;
      end else if (load_d) begin
        valid_c <= 1'b0;
      end
      if (load_d) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (load_a) begin
      vert_a[0] <= vertex_x;
      vert_a[1] <= vertex_y;
      vert_a[2] <= vertex_z;
      clear_a   <= clear_box;
    end
  end

  // clear flag follows the arithmetic stages
  always_ff @(posedge clk) begin
    if (load_b) begin
      clear_b <= clear_a;
    end
    if (load_c) begin
      clear_c <= clear_b;
    end
  end

  // one transform unit per output axis
  for (genvar i = 0; i < 3; i++) begin : g_axis
    vtbb_axis #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_axis (
      .clk          (clk),
      .ctl          (axis_ctl),
      .vertex_x     (vert_a[0]),
      .vertex_y     (vert_a[1]),
      .vertex_z     (vert_a[2]),
      .pass_in      (vert_a[i]),
      .coefs        (row_coefs[i]),
      .shift        (shift[i]),
      .transform_on (transform_on),
      .cam          (cam_c[i])
    );
  end

  // box fold: start from an empty box on clear, then take min and max
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bmin_next[i] = clear_c ? COORD_MAX : bmin[i];
      bmax_next[i] = clear_c ? COORD_MIN : bmax[i];
      if (cam_c[i] < bmin_next[i]) begin
        bmin_next[i] = cam_c[i];
      end
      if (cam_c[i] > bmax_next[i]) begin
        bmax_next[i] = cam_c[i];
      end
    end
  end

  // held box doubles as the result box
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        bmin[i] <= COORD_MAX;
        bmax[i] <= COORD_MIN;
      end
    end else if (load_d) begin
      for (int i = 0; i < 3; i++) begin
        bmin[i] <= bmin_next[i];
        bmax[i] <= bmax_next[i];
      end
    end
  end

  // result point register
  always_ff @(posedge clk) begin
    if (load_d) begin
      for (int i = 0; i < 3; i++) begin
        cam_d[i] <= cam_c[i];
      end
    end
  end

  // result ports
  assign cam_x       = cam_d[0];
  assign cam_y       = cam_d[1];
  assign cam_z       = cam_d[2];
  assign bound_min_x = bmin[0];
  assign bound_max_x = bmax[0];
  assign bound_min_y = bmin[1];
  assign bound_max_y = bmax[1];
  assign bound_min_z = bmin[2];
  assign bound_max_z = bmax[2];

  // a shown result always lies inside the box shown with it
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bound_min_x <= cam_x) && (cam_x <= bound_max_x) &&
                  (bound_min_y <= cam_y) && (cam_y <= bound_max_y) &&
                  (bound_min_z <= cam_z) && (cam_z <= bound_max_z))
    else $error("result point outside its bounding box");

  // a clearing transaction leaves a box of exactly its own point
  assert property (@(posedge clk) disable iff (rst)
    load_d && clear_c |=> (bound_min_x == cam_x) && (bound_max_x == cam_x) &&
                          (bound_min_y == cam_y) && (bound_max_y == cam_y) &&
                          (bound_min_z == cam_z) && (bound_max_z == cam_z))
    else $error("box not reduced to the point after clear");

  // the box only changes when a new result is loaded
  assert property (@(posedge clk) disable iff (rst)
    !load_d |=> $stable(bound_min_x) && $stable(bound_max_x) &&
                $stable(bound_min_y) && $stable(bound_max_y) &&
                $stable(bound_min_z) && $stable(bound_max_z))
    else $error("box changed without a result transaction");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench for the vertex transform and bounding box unit
`timescale 1ns / 1ps

module tb_top;

  localparam int COORD_W = vtbb_pkg::COORD_WIDTH_DEF;
  localparam int COEF_W  = vtbb_pkg::COEF_WIDTH_DEF;
  localparam int FRAC    = COEF_W - 2;
  localparam int ROW_W   = 3 * COEF_W;
  localparam int CFG_W   = (ROW_W > COORD_W) ? ROW_W : COORD_W;

  // register index with no register behind it
  localparam logic [vtbb_pkg::CFG_INDEX_WIDTH-1:0] CFG_IDX_SPARE = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  // cam x/y/z, then min/max pairs for x, y, z
  typedef logic [8:0][COORD_W-1:0] result_t;

  typedef enum logic {STEP_WRITE, STEP_VERTEX} step_kind_t;

  typedef struct packed {
    step_kind_t                           kind;
    logic [vtbb_pkg::CFG_INDEX_WIDTH-1:0] idx;
    logic [CFG_W-1:0]                     data;
    coord_t                               x;
    coord_t                               y;
    coord_t                               z;
    logic                                 clr;
    logic                                 typed;
    result_t                              want;
  } stim_row_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [COEF_W-1:0] COEF_POS_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_NEG_MAX  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_ONE      = COEF_W'(1) << FRAC;
  localparam logic [COEF_W-1:0] COEF_HALF     = COEF_W'(1) << (FRAC - 1);
  localparam logic [COEF_W-1:0] COEF_NEG_HALF = -(COEF_W'(1) << (FRAC - 1));
  localparam logic [COEF_W-1:0] COEF_LSB      = COEF_W'(1);
  localparam logic [COEF_W-1:0] COEF_ZERO     = '0;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic [vtbb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_W-1:0]                     cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  coord_t                               vertex_x = '0;
  coord_t                               vertex_y = '0;
  coord_t                               vertex_z = '0;
  logic                                 clear_box = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  coord_t                               cam_x, cam_y, cam_z;
  coord_t                               bound_min_x, bound_max_x;
  coord_t                               bound_min_y, bound_max_y;
  coord_t                               bound_min_z, bound_max_z;

  // hand-computed result riding along with the current vertex
  logic                        row_typed = 1'b0;
  result_t                     row_want = '0;
  // no idling on either side while set
  logic                        steady = 1'b0;

  // mirror of the block's registers and box
  logic [ROW_W-1:0]            coef_row [3];
  longint                      offset [3];
  logic                        xform_en;
  longint                      box_lo [3];
  longint                      box_hi [3];

  result_t                     pending_results [$];
  stim_row_t                   directed_rows [$];
  int                          mismatch_count = 0;
  string field_names [9] = '{"cam_x", "cam_y", "cam_z", "bound_min_x", "bound_max_x",
                             "bound_min_y", "bound_max_y", "bound_min_z", "bound_max_z"};

  vertex_transform_bound_box_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .vertex_z    (vertex_z),
    .clear_box   (clear_box),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cam_x       (cam_x),
    .cam_y       (cam_y),
    .cam_z       (cam_z),
    .bound_min_x (bound_min_x),
    .bound_max_x (bound_max_x),
    .bound_min_y (bound_min_y),
    .bound_max_y (bound_max_y),
    .bound_min_z (bound_min_z),
    .bound_max_z (bound_max_z)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side drops out_ready at random, 17 times in 100 on average, unless steady is set
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 17);
  end

  // affine transform (or pass-through when off), floor, saturate, then fold into the held box
  function automatic result_t transform_and_fold(coord_t vx, coord_t vy, coord_t vz,
                                                 logic clr);
    longint                    v [3];
    longint                    cam [3];
    longint                    acc;
    logic signed [COEF_W-1:0]  c;
    result_t                   r;
    int                        a, k;
    v[0] = longint'(vx);
    v[1] = longint'(vy);
    v[2] = longint'(vz);
    for (a = 0; a < 3; a++) begin
      if (xform_en) begin
        acc = offset[a] <<< FRAC;
        for (k = 0; k < 3; k++) begin
          c = coef_row[a][k*COEF_W +: COEF_W];
          acc += longint'(c) * v[k];
        end
        acc = acc >>> FRAC;
        if (acc > longint'(C_MAX)) acc = longint'(C_MAX);
        else if (acc < longint'(C_MIN)) acc = longint'(C_MIN);
        cam[a] = acc;
      end else begin
        cam[a] = v[a];
      end
    end
    // clear empties the box so it ends as exactly this point
    if (clr) begin
      for (a = 0; a < 3; a++) begin
        box_lo[a] = longint'(C_MAX);
        box_hi[a] = longint'(C_MIN);
      end
    end
    for (a = 0; a < 3; a++) begin
      if (cam[a] < box_lo[a]) box_lo[a] = cam[a];
      if (cam[a] > box_hi[a]) box_hi[a] = cam[a];
      r[a]         = cam[a][COORD_W-1:0];
      r[3 + 2*a]   = box_lo[a][COORD_W-1:0];
      r[4 + 2*a]   = box_hi[a][COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic result_t pack_result(coord_t cx, coord_t cy, coord_t cz,
                                          coord_t lx, coord_t hx, coord_t ly,
                                          coord_t hy, coord_t lz, coord_t hz);
    return {hz, lz, hy, ly, hx, lx, cz, cy, cx};
  endfunction

  // coordinate mix: extremes, small values near zero, full range
  function automatic coord_t pick_coord();
    int          d;
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return '1;
          default: return coord_t'(1);
        endcase
      end
      1, 2, 3: begin
        d = int'($urandom_range(0, 4095)) - 2048;
        return d[COORD_W-1:0];
      end
      default: begin
        r = $urandom;
        return r[COORD_W-1:0];
      end
    endcase
  endfunction

  // translation per phase: extremes, small, or the usual mix
  function automatic coord_t pick_offset(int phase);
    int d;
    if (phase == 1) return ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
    if (phase == 3) begin
      d = int'($urandom_range(0, 1023)) - 512;
      return d[COORD_W-1:0];
    end
    return pick_coord();
  endfunction

  // coefficient row: full random, extremes, or near a unit row
  function automatic logic [ROW_W-1:0] pick_row(int style, int diag);
    logic [COEF_W-1:0] lane;
    logic [ROW_W-1:0]  row;
    logic [31:0]       r;
    int                d, k;
    row = '0;
    for (k = 0; k < 3; k++) begin
      r = $urandom;
      case (style)
        0: lane = r[COEF_W-1:0];
        1: begin
          case ($urandom_range(0, 4))
            0: lane = COEF_POS_MAX;
            1: lane = COEF_NEG_MAX;
            2: lane = COEF_ZERO;
            3: lane = COEF_ONE;
            default: lane = -COEF_ONE;
          endcase
        end
        default: begin
          d = int'($urandom_range(0, 8191)) - 4096;
          lane = ((k == diag) ? COEF_ONE : COEF_ZERO) + d[COEF_W-1:0];
        end
      endcase
      row[k*COEF_W +: COEF_W] = lane;
    end
    return row;
  endfunction

  // random junk above the bits a narrow register uses
  function automatic logic [CFG_W-1:0] pad_word(logic [COORD_W-1:0] low);
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    return {r64[CFG_W-COORD_W-1:0], low};
  endfunction

  function automatic void add_write(logic [vtbb_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                    logic [CFG_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = STEP_WRITE;
    row.idx  = idx;
    row.data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_vertex(coord_t x, coord_t y, coord_t z, logic clr,
                                     logic typed, result_t want);
    stim_row_t row;
    row = '0;
    row.kind  = STEP_VERTEX;
    row.x     = x;
    row.y     = y;
    row.z     = z;
    row.clr   = clr;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // stop sending and let every expected result come out; the first edge
  // lets a transaction accepted at the previous edge reach the queue
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // register write while idle, mirrored for the prediction
  task automatic write_reg(logic [vtbb_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           logic [CFG_W-1:0] data);
    coord_t sh;
    wait_drained();
    sh = data[COORD_W-1:0];
    case (idx)
      vtbb_pkg::CFG_ROW_X, vtbb_pkg::CFG_ROW_Y, vtbb_pkg::CFG_ROW_Z:
        coef_row[idx] = data[ROW_W-1:0];
      vtbb_pkg::CFG_SHIFT_X:      offset[0] = longint'(sh);
      vtbb_pkg::CFG_SHIFT_Y:      offset[1] = longint'(sh);
      vtbb_pkg::CFG_SHIFT_Z:      offset[2] = longint'(sh);
      vtbb_pkg::CFG_TRANSFORM_ON: xform_en = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one vertex transaction, with a random gap in front unless steady is set
  task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic clr,
                             logic typed, result_t want);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(0, 99) < 17) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    vertex_x  <= x;
    vertex_y  <= y;
    vertex_z  <= z;
    clear_box <= clr;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // predict on each vertex transaction, check each result transaction
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    result_t pred;
    int      f;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {bound_max_z, bound_min_z, bound_max_y, bound_min_y,
               bound_max_x, bound_min_x, cam_z, cam_y, cam_x};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transaction with no vertex pending", $time);
        end else begin
          want = pending_results.pop_front();
          for (f = 0; f < 9; f++) begin
            if (got[f] !== want[f]) begin
              mismatch_count++;
              $display("%0t: %s expected %0d, got %0d", $time, field_names[f],
                       $signed(want[f]), $signed(got[f]));
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        pred = transform_and_fold(vertex_x, vertex_y, vertex_z, clear_box);
        pending_results.push_back(row_typed ? row_want : pred);
      end
    end
  end

  // stimulus: directed table, then random phases
  initial begin
    stim_row_t   row;
    logic [31:0] r;
    logic [63:0] r64;
    int          p, n, i, style;

    // state after reset: identity, no translation, empty box
    for (i = 0; i < 3; i++) begin
      coef_row[i] = '0;
      coef_row[i][i*COEF_W +: COEF_W] = COEF_ONE;
      offset[i] = 0;
      box_lo[i] = longint'(C_MAX);
      box_hi[i] = longint'(C_MIN);
    end
    xform_en = 1'b1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // identity after reset: point passes, box grows from empty
    add_vertex('0, '0, '0, 1'b0, 1'b1, pack_result('0, '0, '0, '0, '0, '0, '0, '0, '0));
    add_vertex(C_MAX, C_MIN, coord_t'(1), 1'b0, 1'b1,
               pack_result(C_MAX, C_MIN, coord_t'(1), '0, C_MAX, C_MIN, '0, '0,
                           coord_t'(1)));
    add_vertex(C_MIN, C_MAX, '1, 1'b1, 1'b1,
               pack_result(C_MIN, C_MAX, '1, C_MIN, C_MIN, C_MAX, C_MAX, '1, '1));
    add_vertex('1, '1, '1, 1'b0, 1'b1,
               pack_result('1, '1, '1, C_MIN, '1, '1, C_MAX, '1, '1));
    // write to the unused index must leave the identity in place
    add_write(CFG_IDX_SPARE, '1);
    add_vertex(coord_t'(5), coord_t'(-5), coord_t'(7), 1'b1, 1'b1,
               pack_result(coord_t'(5), coord_t'(-5), coord_t'(7), coord_t'(5),
                           coord_t'(5), coord_t'(-5), coord_t'(-5), coord_t'(7),
                           coord_t'(7)));
    // extreme coefficients and translations: saturation both ways
    add_write(vtbb_pkg::CFG_ROW_X, {COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX});
    add_write(vtbb_pkg::CFG_ROW_Y, {COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX});
    add_write(vtbb_pkg::CFG_ROW_Z, {COEF_LSB, COEF_POS_MAX, COEF_NEG_MAX});
    add_write(vtbb_pkg::CFG_SHIFT_X, pad_word(C_MAX));
    add_write(vtbb_pkg::CFG_SHIFT_Y, pad_word(C_MIN));
    add_write(vtbb_pkg::CFG_SHIFT_Z, pad_word(coord_t'(1)));
    add_vertex(C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, '0);
    add_vertex(C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, '0);
    add_vertex('0, '0, '0, 1'b0, 1'b0, '0);
    add_vertex(C_MAX, C_MIN, '0, 1'b0, 1'b0, '0);
    add_vertex(coord_t'(1), '1, '1, 1'b0, 1'b0, '0);
    // halves and the smallest coefficient: floor on negative values
    add_write(vtbb_pkg::CFG_ROW_X, {COEF_ZERO, COEF_ZERO, COEF_HALF});
    add_write(vtbb_pkg::CFG_ROW_Y, {COEF_ZERO, COEF_NEG_HALF, COEF_ZERO});
    add_write(vtbb_pkg::CFG_ROW_Z, {COEF_LSB, COEF_ZERO, COEF_ZERO});
    add_write(vtbb_pkg::CFG_SHIFT_X, pad_word('0));
    add_write(vtbb_pkg::CFG_SHIFT_Y, pad_word(coord_t'(1)));
    add_write(vtbb_pkg::CFG_SHIFT_Z, pad_word('1));
    add_vertex(coord_t'(1), coord_t'(1), coord_t'(1), 1'b1, 1'b0, '0);
    add_vertex('1, '1, '1, 1'b0, 1'b0, '0);
    add_vertex(coord_t'(3), coord_t'(-3), C_MAX, 1'b0, 1'b0, '0);
    add_vertex(coord_t'(-3), coord_t'(3), C_MIN, 1'b0, 1'b0, '0);
    // transform off: vertex passes unchanged
    add_write(vtbb_pkg::CFG_TRANSFORM_ON, {{(CFG_W-1){1'b1}}, 1'b0});
    add_vertex(C_MAX, C_MIN, '1, 1'b1, 1'b1,
               pack_result(C_MAX, C_MIN, '1, C_MAX, C_MAX, C_MIN, C_MIN, '1, '1));
    add_vertex(C_MIN, C_MAX, '0, 1'b0, 1'b1,
               pack_result(C_MIN, C_MAX, '0, C_MIN, C_MAX, C_MIN, C_MAX, '1, '0));
    add_vertex(coord_t'(123), coord_t'(-456), coord_t'(789), 1'b1, 1'b1,
               pack_result(coord_t'(123), coord_t'(-456), coord_t'(789),
                           coord_t'(123), coord_t'(123), coord_t'(-456),
                           coord_t'(-456), coord_t'(789), coord_t'(789)));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == STEP_WRITE) write_reg(row.idx, row.data);
      else send_vertex(row.x, row.y, row.z, row.clr, row.typed, row.want);
    end

    // random phases, each after a full drain and a new register set
    for (p = 0; p < 5; p++) begin
      case (p)
        1: style = 1;
        3: style = 2;
        4: style = int'($urandom_range(0, 2));
        default: style = 0;
      endcase
      write_reg(vtbb_pkg::CFG_ROW_X, pick_row(style, 0));
      write_reg(vtbb_pkg::CFG_ROW_Y, pick_row(style, 1));
      write_reg(vtbb_pkg::CFG_ROW_Z, pick_row(style, 2));
      write_reg(vtbb_pkg::CFG_SHIFT_X, pad_word(pick_offset(p)));
      write_reg(vtbb_pkg::CFG_SHIFT_Y, pad_word(pick_offset(p)));
      write_reg(vtbb_pkg::CFG_SHIFT_Z, pad_word(pick_offset(p)));
      r = $urandom;
      r[0] = (p != 2);
      write_reg(vtbb_pkg::CFG_TRANSFORM_ON, pad_word(r[COORD_W-1:0]));
      if (p == 4) begin
        r64 = {$urandom, $urandom};
        write_reg(CFG_IDX_SPARE, r64[CFG_W-1:0]);
      end
      steady <= (p == 3);
      for (n = 0; n < 170; n++) begin
        send_vertex(pick_coord(), pick_coord(), pick_coord(),
                    ($urandom_range(0, 7) == 0), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
